// File: sv/ipmb_pkg.sv
// ----------------------------------------------------------------------------
// ipmb_pkg
// Shared types and codes of the IP-to-MAC binding table.
// ----------------------------------------------------------------------------
package ipmb_pkg;

  // Operation codes carried by an input beat
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_EDIT   = 2'd2;
  localparam logic [1:0] OP_CHECK  = 2'd3;

  // Status codes of a result beat
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXISTS    = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [1:0] STATUS_FULL      = 2'd3;

  // Verdict codes of a check
  localparam logic [1:0] VERDICT_PASS  = 2'd0;
  localparam logic [1:0] VERDICT_BLOCK = 2'd1;
  localparam logic [1:0] VERDICT_WARN  = 2'd2;

  // Slot flag bit positions
  localparam int FLAG_VALID  = 0;
  localparam int FLAG_BLOCK  = 1;
  localparam int FLAG_ENABLE = 2;

  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int FLAG_W  = 3;
  localparam int COUNT_W = 10;

  // Write request into the slot store
  typedef struct packed {
    logic              en;       // write the flags of the addressed slot
    logic              key_en;   // also write ip and mac
    logic [FLAG_W-1:0] flags;
  } slot_wr_t;

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

endpackage

// File: sv/ipmb_slot_store.sv
// ----------------------------------------------------------------------------
// ipmb_slot_store
// Slot memories (ip, mac, flags): one write port, one registered read port.
// ----------------------------------------------------------------------------
module ipmb_slot_store #(
  parameter int SLOTS     = 512,
  parameter int SLOT_BITS = 9
) (
  input  logic                          clk,
  input  logic [SLOT_BITS-1:0]          rd_addr,
  output logic [ipmb_pkg::IP_W-1:0]     rd_ip,
  output logic [ipmb_pkg::MAC_W-1:0]    rd_mac,
  output logic [ipmb_pkg::FLAG_W-1:0]   rd_flags,
  input  logic [SLOT_BITS-1:0]          wr_addr,
  input  ipmb_pkg::slot_wr_t            wr_req,
  input  logic [ipmb_pkg::IP_W-1:0]     wr_ip,
  input  logic [ipmb_pkg::MAC_W-1:0]    wr_mac
);
  import ipmb_pkg::*;

  logic [IP_W-1:0]   ip_mem   [SLOTS];
  logic [MAC_W-1:0]  mac_mem  [SLOTS];
  logic [FLAG_W-1:0] flag_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      flag_mem[wr_addr] <= wr_req.flags;
    end
    if (wr_req.en && wr_req.key_en) begin
      ip_mem[wr_addr]  <= wr_ip;
      mac_mem[wr_addr] <= wr_mac;
    end
  end

  always_ff @(posedge clk) begin
    rd_ip    <= ip_mem[rd_addr];
    rd_mac   <= mac_mem[rd_addr];
    rd_flags <= flag_mem[rd_addr];
  end

endmodule

// File: sv/ip_mac_binding_table.sv
// ----------------------------------------------------------------------------
// ip_mac_binding_table
// Hashed table of IPv4-to-MAC bindings with add, delete, edit and check.
// ----------------------------------------------------------------------------
// The table holds (1 << BUCKET_BITS) * WAYS slots; an address lives in bucket
// (ip ^ (ip[31:16] >> BUCKET_BITS) ^ ip[31:16]) masked to BUCKET_BITS bits,
// in the lowest free way at the time of its add. Every input beat gives
// exactly one result beat. After reset the block runs a clearing pass over
// the flag memory, one slot per cycle, and in_ready stays low until it is
// done. For each operation the sequencer then reads the bucket's ways one
// per cycle through the single read port of the slot memory and runs each
// through one shared IP comparator as its data returns from the registered
// read port; then the decide step writes back, and the sequencer returns to
// idle to accept. A result beat waits in an output register, so the next
// beat is accepted while it waits; the decide step only stalls when the
// previous result has still not been taken. rule_count is the number of
// stored rules after the operation, modulo 1024.
// ----------------------------------------------------------------------------
module ip_mac_binding_table #(
  parameter int BUCKET_BITS = 7,
  parameter int WAYS        = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     operation,
  input  logic [ipmb_pkg::IP_W-1:0]      ip_address,
  input  logic [ipmb_pkg::MAC_W-1:0]     mac_address,
  input  logic                           block_action,
  input  logic                           rule_enable,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic [1:0]                     verdict,
  output logic [ipmb_pkg::COUNT_W-1:0]   rule_count
);
  import ipmb_pkg::*;

  localparam int SLOTS     = (1 << BUCKET_BITS) * WAYS;
  localparam int SLOT_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WC        = $clog2(WAYS + 1);

  state_t state, state_next;

  // Latched operation
  logic [1:0]       op;
  logic [IP_W-1:0]  ip;
  logic [MAC_W-1:0] mac;
  logic             blk;
  logic             en;

  logic [SLOT_BITS-1:0] slot_base;
  logic [SLOT_BITS-1:0] clr_addr;

  // Scan bookkeeping
  logic [WC-1:0]     issue_way;
  logic              rd_valid;
  logic [WC-1:0]     rd_way;
  logic              hit_found;
  logic [WC-1:0]     hit_way;
  logic              free_found;
  logic [WC-1:0]     free_way;
  logic [MAC_W-1:0]  hit_mac;
  logic [FLAG_W-1:0] hit_flags;

  logic [COUNT_W-1:0] count, count_next;

  // Store interface
  logic [SLOT_BITS-1:0] rd_addr;
  logic [IP_W-1:0]      rd_ip;
  logic [MAC_W-1:0]     rd_mac;
  logic [FLAG_W-1:0]    rd_flags;
  logic [SLOT_BITS-1:0] wr_addr;
  slot_wr_t             wr_req;

  logic                   accept;
  logic                   issue;
  logic                   ip_match;
  logic                   scan_done;
  logic                   out_free;
  logic                   decide_go;
  logic [15:0]            ip_hi;
  logic [IP_W-1:0]        hash_mix;
  logic [BUCKET_BITS-1:0] bucket;
  logic [1:0]             status_next;
  logic [1:0]             verdict_next;

  // Bucket hash of the incoming address
  assign ip_hi    = ip_address[31:16];
  assign hash_mix = ip_address ^ {16'd0, ip_hi >> BUCKET_BITS} ^ {16'd0, ip_hi};
  assign bucket   = hash_mix[BUCKET_BITS-1:0];

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  assign issue     = (state == ST_SCAN) && (issue_way != WC'(WAYS));
  assign rd_addr   = slot_base + SLOT_BITS'(issue_way);
  assign ip_match  = (rd_ip == ip);   // the shared comparator
  assign scan_done = rd_valid && (rd_way == WC'(WAYS - 1));
  assign out_free  = !out_valid || out_ready;
  assign decide_go = (state == ST_DECIDE) && out_free;

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == SLOT_BITS'(SLOTS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + SLOT_BITS'(1);
    end
  end

  // Latch the beat and the bucket base on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op        <= operation;
      ip        <= ip_address;
      mac       <= mac_address;
      blk       <= block_action;
      en        <= rule_enable;
      slot_base <= SLOT_BITS'(bucket) * SLOT_BITS'(WAYS);
    end
  end

  // Walk the ways: issue one read per cycle, compare the one that returns
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      issue_way  <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (issue) issue_way <= issue_way + WC'(1);
      if (rd_valid) begin
        if (rd_flags[FLAG_VALID] && ip_match && !hit_found) begin
          hit_found <= 1'b1;
          hit_way   <= rd_way;
          hit_mac   <= rd_mac;
          hit_flags <= rd_flags;
        end
        if (!rd_flags[FLAG_VALID] && !free_found) begin
          free_found <= 1'b1;
          free_way   <= rd_way;
        end
      end
    end
    rd_way <= issue_way;
  end

  // Decide the outcome and the write-back
  always_comb begin
    status_next  = STATUS_OK;
    verdict_next = VERDICT_PASS;
    count_next   = count;
    wr_req       = '0;
    wr_addr      = slot_base + SLOT_BITS'(hit_way);
    case (op)
      OP_ADD: begin
        wr_addr = slot_base + SLOT_BITS'(free_way);
        if (hit_found) begin
          status_next = STATUS_EXISTS;
        end else if (free_found) begin
          wr_req.en     = 1'b1;
          wr_req.key_en = 1'b1;
          count_next    = count + COUNT_W'(1);
        end else begin
          status_next = STATUS_FULL;
        end
      end
      OP_DELETE: begin
        if (hit_found) begin
          wr_req.en  = 1'b1;
          count_next = count - COUNT_W'(1);
        end
      end
      OP_EDIT: begin
        if (hit_found) begin
          wr_req.en     = 1'b1;
          wr_req.key_en = 1'b1;
        end else begin
          status_next = STATUS_NOT_FOUND;
        end
      end
      OP_CHECK: begin
        if ((mac != '0) && hit_found && hit_flags[FLAG_ENABLE] && (hit_mac != mac)) begin
          verdict_next = hit_flags[FLAG_BLOCK] ? VERDICT_BLOCK : VERDICT_WARN;
        end
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
    if (wr_req.en && (op != OP_DELETE)) begin
      wr_req.flags              = '0;
      wr_req.flags[FLAG_VALID]  = 1'b1;
      wr_req.flags[FLAG_BLOCK]  = blk;
      wr_req.flags[FLAG_ENABLE] = en;
    end
    // Hold off the write until the result can be registered
    if (!decide_go) begin
      wr_req = '0;
    end
    // Clearing pass owns the write port after reset
    if (state == ST_CLEAR) begin
      wr_req    = '0;
      wr_req.en = 1'b1;
      wr_addr   = clr_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (decide_go) begin
      count <= count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (decide_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide_go) begin
      status     <= status_next;
      verdict    <= verdict_next;
      rule_count <= count_next;
    end
  end

  ipmb_slot_store #(
    .SLOTS     (SLOTS),
    .SLOT_BITS (SLOT_BITS)
  ) u_store (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .rd_ip    (rd_ip),
    .rd_mac   (rd_mac),
    .rd_flags (rd_flags),
    .wr_addr  (wr_addr),
    .wr_req   (wr_req),
    .wr_ip    (ip),
    .wr_mac   (mac)
  );

endmodule

// File: sv/ipmb_checker.sv
// ----------------------------------------------------------------------------
// ipmb_checker
// Port-level checks of the IP-to-MAC binding table, bound to the top level.
// ----------------------------------------------------------------------------
module ipmb_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    status,
  input logic [1:0]                    verdict,
  input logic [ipmb_pkg::COUNT_W-1:0]  rule_count
);
  import ipmb_pkg::*;

  // Clearing pass holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ready high right after reset");

  // One beat at a time: busy in the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accept");

  // Only a successful check may carry a non-pass verdict
  a_verdict_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (verdict != VERDICT_PASS)) |-> (status == STATUS_OK))
    else $error("verdict set on a failed operation");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((verdict == VERDICT_PASS) || (verdict == VERDICT_BLOCK) ||
                   (verdict == VERDICT_WARN)))
    else $error("verdict code out of range");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(verdict) && $stable(rule_count)))
    else $error("result beat changed while stalled");

endmodule

bind ip_mac_binding_table ipmb_checker u_ipmb_checker (.*);

// File: dv/tb_ip_mac_binding_table.sv
// ----------------------------------------------------------------------------
// tb_ip_mac_binding_table
// Self-checking bench for the hashed IP-to-MAC binding table.
// ----------------------------------------------------------------------------
// A shadow copy of the slot store predicts the status, verdict and rule count
// of every accepted request beat. Result beats are matched in order against
// that prediction. A directed pass walks through the corner cases: a full
// bucket, duplicate add, absent edit and delete, and every check outcome.
// A long random pass follows. Most of it works a few crowded buckets and a
// small set of MACs, so that collisions and mismatches happen often. Both
// sides idle in short random bursts except near the end of the run.
// ----------------------------------------------------------------------------
module tb_ip_mac_binding_table;
  timeunit 1ns;
  timeprecision 1ps;

  import ipmb_pkg::*;

  localparam int BUCKET_BITS  = 7;
  localparam int WAYS         = 4;
  localparam int BUCKETS      = 1 << BUCKET_BITS;
  localparam int SLOTS        = BUCKETS * WAYS;
  localparam int RANDOM_BEATS = 2000;
  localparam int CALM_BEATS   = 300;   // tail of the run with no idling
  localparam int HOT_BUCKETS  = 3;
  localparam int HOT_PER      = 6;     // more keys than ways, so buckets fill
  localparam int HOT_KEYS     = HOT_BUCKETS * HOT_PER;
  localparam int SETTLE       = 4 * (WAYS + 3);

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         verdict;
    logic [COUNT_W-1:0] rule_count;
  } binding_result_t;

  // --------------------------------------------------------------------------
  // Shadow table: predicts each result and checks the result beats in order
  // --------------------------------------------------------------------------
  class binding_shadow;
    logic [IP_W-1:0]    key_ip [SLOTS];
    logic [MAC_W-1:0]   key_mac[SLOTS];
    bit                 in_use [SLOTS];
    bit                 blocks [SLOTS];
    bit                 enabled[SLOTS];
    logic [COUNT_W-1:0] rules;
    binding_result_t    pending_results[$];
    int                 fail_count;
    int                 op_seen[4];
    int                 status_seen[4];
    int                 verdict_seen[4];
    int                 peak_rules;

    function void clear_table();
      for (int s = 0; s < SLOTS; s++) begin
        in_use[s] = 1'b0;
      end
      rules      = '0;
      fail_count = 0;
      peak_rules = 0;
      for (int k = 0; k < 4; k++) begin
        op_seen[k]      = 0;
        status_seen[k]  = 0;
        verdict_seen[k] = 0;
      end
    endfunction

    function int bucket_of(logic [IP_W-1:0] ip);
      logic [IP_W-1:0] upper;
      upper = {16'h0, ip[31:16]};
      return int'((ip ^ (upper >> BUCKET_BITS) ^ upper) & (BUCKETS - 1));
    endfunction

    // Apply one accepted request to the shadow table and queue its result.
    function void note_request(logic [1:0] op, logic [IP_W-1:0] ip,
                               logic [MAC_W-1:0] mac, logic blk, logic en);
      int              base;
      int              hit;
      binding_result_t res;
      base = bucket_of(ip) * WAYS;
      hit  = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (hit < 0 && in_use[base + w] && key_ip[base + w] == ip) hit = base + w;
      end
      res.status  = STATUS_OK;
      res.verdict = VERDICT_PASS;
      case (op)
        OP_ADD: begin
          if (hit >= 0) begin
            res.status = STATUS_EXISTS;
          end else begin
            res.status = STATUS_FULL;
            // lowest free way wins
            for (int w = 0; w < WAYS; w++) begin
              if (res.status == STATUS_FULL && !in_use[base + w]) begin
                key_ip[base + w]  = ip;
                key_mac[base + w] = mac;
                in_use[base + w]  = 1'b1;
                blocks[base + w]  = blk;
                enabled[base + w] = en;
                rules             = rules + 1'b1;
                res.status        = STATUS_OK;
              end
            end
          end
        end
        OP_DELETE: begin
          if (hit >= 0) begin
            in_use[hit] = 1'b0;
            rules       = rules - 1'b1;
          end
        end
        OP_EDIT: begin
          if (hit >= 0) begin
            key_mac[hit] = mac;
            blocks[hit]  = blk;
            enabled[hit] = en;
          end else begin
            res.status = STATUS_NOT_FOUND;
          end
        end
        default: begin
          if (mac != '0 && hit >= 0 && enabled[hit] && key_mac[hit] != mac)
            res.verdict = blocks[hit] ? VERDICT_BLOCK : VERDICT_WARN;
        end
      endcase
      res.rule_count = rules;
      op_seen[op]++;
      status_seen[res.status]++;
      verdict_seen[res.verdict]++;
      if (int'(rules) > peak_rules) peak_rules = int'(rules);
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [1:0] st, logic [1:0] vd,
                               logic [COUNT_W-1:0] cnt);
      binding_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d verdict %0d count %0d",
               st, vd, cnt);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      if (st !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, st);
        fail_count++;
      end
      if (vd !== want.verdict) begin
        $error("verdict: expected %0d, actual %0d", want.verdict, vd);
        fail_count++;
      end
      if (cnt !== want.rule_count) begin
        $error("rule_count: expected %0d, actual %0d", want.rule_count, cnt);
        fail_count++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [1:0]         operation    = OP_CHECK;
  logic [IP_W-1:0]    ip_address   = '0;
  logic [MAC_W-1:0]   mac_address  = '0;
  logic               block_action = 1'b0;
  logic               rule_enable  = 1'b0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [1:0]         status;
  logic [1:0]         verdict;
  logic [COUNT_W-1:0] rule_count;

  bit                 idle_on    = 1'b1;  // random idling on both sides
  int                 ready_hold = 0;

  binding_shadow      sb;
  logic [IP_W-1:0]    hot_ip[HOT_KEYS];
  logic [MAC_W-1:0]   mac_pool[4];
  logic [IP_W-1:0]    seen_ips[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ip_mac_binding_table #(
    .BUCKET_BITS (BUCKET_BITS),
    .WAYS        (WAYS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .ip_address   (ip_address),
    .mac_address  (mac_address),
    .block_action (block_action),
    .rule_enable  (rule_enable),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .verdict      (verdict),
    .rule_count   (rule_count)
  );

  // Result side: drop ready in short random bursts while idling is on.
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      ready_hold <= $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: values read here are the ones the DUT saw at this edge, since
  // every bench input and every DUT register changes in the NBA region.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(status, verdict, rule_count);
      if (in_valid && in_ready)
        sb.note_request(operation, ip_address, mac_address, block_action, rule_enable);
    end
  end

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  // Called right after a rising edge. Optionally idle first, then present
  // the beat and hold it. in_ready is sampled at the falling edge, where it
  // is settled, so the handshake lands on the following rising edge.
  task automatic send_request(input logic [1:0] op, input logic [IP_W-1:0] ip,
                              input logic [MAC_W-1:0] mac, input logic blk,
                              input logic en);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    ip_address   <= ip;
    mac_address  <= mac;
    block_action <= blk;
    rule_enable  <= en;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  // Hold the request side low until every outstanding result is back. The
  // queue is read at the falling edge, after the monitor has run.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Build an address that hashes into the given bucket; upper half random.
  function automatic logic [IP_W-1:0] ip_in_bucket(int bkt);
    logic [15:0] upper;
    logic [15:0] lower;
    logic [15:0] mask;
    upper = 16'($urandom);
    mask  = 16'(BUCKETS - 1);
    lower = (16'($urandom) & ~mask) |
            ((16'(bkt) ^ upper ^ (upper >> BUCKET_BITS)) & mask);
    return {upper, lower};
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [IP_W-1:0]  a[5];
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [63:0]      wide;
    logic [1:0]       op;
    int               pick;

    sb = new;
    sb.clear_table();

    mac_pool[0] = 48'h02_00_5E_10_00_01;
    mac_pool[1] = 48'hA5_5A_A5_5A_A5_5A;
    mac_pool[2] = 48'h5A_A5_5A_A5_5A_A5;
    mac_pool[3] = 48'hFF_FF_FF_FF_FF_FE;

    // crowded buckets: the first and last bucket plus bucket 17
    for (int k = 0; k < HOT_KEYS; k++) begin
      case (k / HOT_PER)
        0:       hot_ip[k] = ip_in_bucket(0);
        1:       hot_ip[k] = ip_in_bucket(BUCKETS - 1);
        default: hot_ip[k] = ip_in_bucket(17);
      endcase
    end
    for (int k = 0; k < 5; k++) a[k] = ip_in_bucket($urandom_range(1, BUCKETS - 2));
    // keep the five directed keys in one bucket
    for (int k = 1; k < 5; k++) a[k] = ip_in_bucket(sb.bucket_of(a[0]));

    // hold reset at the start, then release it; the DUT then clears its flag memory
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // ---- directed pass ----
    // fill one bucket, with a duplicate add on the way, then overflow it
    send_request(OP_ADD,    a[0], mac_pool[0], 1'b1, 1'b1);
    send_request(OP_ADD,    a[0], mac_pool[1], 1'b0, 1'b1);
    send_request(OP_ADD,    a[1], mac_pool[1], 1'b0, 1'b1);
    send_request(OP_ADD,    a[2], 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_request(OP_ADD,    a[3], mac_pool[2], 1'b1, 1'b1);
    send_request(OP_ADD,    a[4], mac_pool[0], 1'b1, 1'b1);
    // every check outcome: match, block, warn, disabled, absent, zero MAC
    send_request(OP_CHECK,  a[0], mac_pool[0], 1'b0, 1'b0);
    send_request(OP_CHECK,  a[0], mac_pool[1], 1'b0, 1'b0);
    send_request(OP_CHECK,  a[1], mac_pool[0], 1'b1, 1'b1);
    send_request(OP_CHECK,  a[2], mac_pool[0], 1'b0, 1'b0);
    send_request(OP_CHECK,  a[4], mac_pool[0], 1'b0, 1'b0);
    send_request(OP_CHECK,  a[0], '0,          1'b0, 1'b0);
    // edit absent and present, delete absent and present, reuse a freed way
    send_request(OP_EDIT,   a[4], mac_pool[2], 1'b1, 1'b1);
    send_request(OP_EDIT,   a[1], mac_pool[1], 1'b1, 1'b1);
    send_request(OP_CHECK,  a[1], mac_pool[2], 1'b0, 1'b0);
    send_request(OP_DELETE, a[4], '0,          1'b0, 1'b0);
    send_request(OP_DELETE, a[1], '0,          1'b0, 1'b0);
    send_request(OP_ADD,    a[4], mac_pool[3], 1'b0, 1'b1);
    send_request(OP_CHECK,  a[4], mac_pool[0], 1'b0, 1'b0);
    // field extremes
    send_request(OP_ADD,    32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_request(OP_ADD,    32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b0, 1'b1);
    send_request(OP_CHECK,  32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_request(OP_CHECK,  32'h0000_0000, 48'h0000_0000_0001, 1'b0, 1'b0);
    send_request(OP_DELETE, 32'h0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_request(OP_EDIT,   32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);

    // pause the sender until every result is back
    drain_results();
    @(posedge clk);

    // ---- random pass ----
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS - CALM_BEATS) idle_on = 1'b0;

      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        ip = hot_ip[$urandom_range(0, HOT_KEYS - 1)];
      end else if (pick < 85 && seen_ips.size() > 0) begin
        ip = seen_ips[$urandom_range(0, seen_ips.size() - 1)];
      end else begin
        ip = $urandom;
        seen_ips.push_back(ip);
        if (seen_ips.size() > 64) void'(seen_ips.pop_front());
      end

      pick = $urandom_range(0, 99);
      if (pick < 35)      op = OP_ADD;
      else if (pick < 50) op = OP_DELETE;
      else if (pick < 65) op = OP_EDIT;
      else                op = OP_CHECK;

      // mostly pooled MACs so checks match often; some zero, some random
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        mac = mac_pool[pick % 4];
      end else if (pick == 6) begin
        mac = '0;
      end else begin
        wide = {$urandom, $urandom};
        mac  = wide[MAC_W-1:0];
      end

      send_request(op, ip, mac, 1'($urandom), 1'($urandom_range(0, 4) != 0));
    end

    // ---- wind down ----
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      $error("%0d results never arrived", sb.pending_results.size());
      sb.fail_count++;
    end

    $display("Covered %0d requests: add %0d, delete %0d, edit %0d, check %0d; peak %0d rules",
             sb.op_seen[OP_ADD] + sb.op_seen[OP_DELETE] + sb.op_seen[OP_EDIT] +
             sb.op_seen[OP_CHECK], sb.op_seen[OP_ADD], sb.op_seen[OP_DELETE],
             sb.op_seen[OP_EDIT], sb.op_seen[OP_CHECK], sb.peak_rules);
    $display("Outcomes: exists %0d, not found %0d, bucket full %0d; block %0d, warn %0d",
             sb.status_seen[STATUS_EXISTS], sb.status_seen[STATUS_NOT_FOUND],
             sb.status_seen[STATUS_FULL], sb.verdict_seen[VERDICT_BLOCK],
             sb.verdict_seen[VERDICT_WARN]);
    if (sb.fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (clearing pass, then every
  // beat waiting out its scan and decide plus the longest gaps and stalls).
  initial begin
    #1_000_000;
    $display("Run timed out");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: filelist.f
sv/ipmb_pkg.sv
sv/ipmb_slot_store.sv
sv/ip_mac_binding_table.sv
sv/ipmb_checker.sv
dv/tb_ip_mac_binding_table.sv
